FILE: sv/key_chord_matcher_macros.svh
// ----------------------------------------------------------------------------
// Key chord matcher assertion macros
// Shorthands for clocked assertions on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef KEY_CHORD_MATCHER_MACROS_SVH
`define KEY_CHORD_MATCHER_MACROS_SVH

// Same-cycle implication.
`define KCM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("key_chord_matcher: same-cycle check failed");

// Next-cycle implication.
`define KCM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("key_chord_matcher: next-cycle check failed");

`endif

FILE: sv/kcm_pkg.sv
// ----------------------------------------------------------------------------
// Key chord matcher package
// Sizes, event codes, item and chord register layouts shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package kcm_pkg;

    // Sizing of the held key set and the chord table.
    localparam int HELD_MAX   = 8;
    localparam int NUM_CHORDS = 8;
    localparam int REG_COUNT  = 8;
    localparam int CHORD_KEYS = 3;
    localparam int KEY_W      = 16;
    localparam int CNT_W      = $clog2(HELD_MAX + 1);
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int CFG_IDX_W  = 8;
    localparam int CHORD_W    = 59;

    // Event kinds; any other code leaves the held set alone.
    localparam logic [1:0] FUNC_DOWN = 2'd0;
    localparam logic [1:0] FUNC_UP   = 2'd1;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic       fired;
        logic [7:0] action_code;
        logic       overflow;
        logic [3:0] held_count;
    } out_item_t;

    // One chord register, bit 58 down to bit 0.
    typedef struct packed {
        logic             valid;
        logic [7:0]       code;
        logic [1:0]       count;
        logic [KEY_W-1:0] key2;
        logic [KEY_W-1:0] key1;
        logic [KEY_W-1:0] key0;
    } chord_t;

    // Per-cell update commands.
    typedef struct packed {
        logic append;
        logic shift;
    } cell_ctl_t;

    // Outcome of the chord search.
    typedef struct packed {
        logic       fired;
        logic [7:0] code;
    } match_t;

endpackage

`default_nettype wire

FILE: sv/kcm_cell.sv
// ----------------------------------------------------------------------------
// Held key cell
// One slot of the held key row: compares its key with the event key, passes
// the "hit at or below" flag upward and shifts down to close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_cell
    import kcm_pkg::*;
(
    input  wire logic             aclk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [KEY_W-1:0] ev_key,
    input  wire logic             occupied,
    input  wire logic             kill_in,
    input  wire logic [KEY_W-1:0] next_key,
    output logic                  kill_out,
    output logic [KEY_W-1:0]      key
);

    logic [KEY_W-1:0] key_reg;
    logic             hit;

    // A released key at or below this slot moves the upper neighbor down.
    assign hit      = occupied && (key_reg == ev_key);
    assign kill_out = kill_in || hit;
    assign key      = key_reg;

    always_ff @(posedge aclk) begin
        if (ctl.append) begin
            key_reg <= ev_key;
        end else if (ctl.shift && kill_out) begin
            key_reg <= next_key;
        end
    end

endmodule

`default_nettype wire

FILE: sv/kcm_match.sv
// ----------------------------------------------------------------------------
// Chord search
// Checks every chord entry against the lowest held keys and picks the
// lowest-numbered entry that matches.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_match
    import kcm_pkg::*;
(
    input  wire logic [CHORD_KEYS-1:0][KEY_W-1:0] held_key,
    input  wire logic [CNT_W-1:0]                 count,
    input  wire chord_t                           chords [NUM_CHORDS],
    output match_t                                result
);

    logic [NUM_CHORDS-1:0] hit;

    // With equal sizes and distinct held keys, every held key being in the
    // chord is the same as the two multisets being equal.
    always_comb begin
        logic all_in;
        logic [1:0] cnt;
        for (int c = 0; c < NUM_CHORDS; c++) begin
            cnt    = chords[c].count;
            all_in = 1'b1;
            for (int j = 0; j < CHORD_KEYS; j++) begin
                if (j < int'(cnt)) begin
                    all_in = all_in &&
                        ((held_key[j] == chords[c].key0) ||
                         ((cnt > 2'd1) && (held_key[j] == chords[c].key1)) ||
                         ((cnt > 2'd2) && (held_key[j] == chords[c].key2)));
                end
            end
            hit[c] = chords[c].valid && (count == CNT_W'(cnt)) && all_in;
        end
    end

    // Priority pick, lowest entry wins.
    always_comb begin
        result = '0;
        for (int c = NUM_CHORDS - 1; c >= 0; c--) begin
            if (hit[c]) begin
                result.fired = 1'b1;
                result.code  = chords[c].code;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/key_chord_matcher.sv
// ----------------------------------------------------------------------------
// Key chord matcher
// Tracks the set of held keys and fires the first configured chord that
// equals it.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on s_valid/s_ready with s_data (func, key_code); one result
//   item per event leaves on m_valid/m_ready with m_data (fired, action_code,
//   overflow, held_count).
//   Chords are written on cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high and indexes beyond the table are dropped.
//   Write chords only while no event is in flight.
//   Each event passes through capture, then the cell row step that looks
//   up, appends or removes the key, then the chord search over all entries
//   in parallel. The search result is registered in the output register,
//   and no new event is taken until the last one leaves the search step.
//   The output register lets the next event enter while a result waits; if
//   m_ready stays low the second event holds in the search step until the
//   output register frees, and s_ready stays low meanwhile.
//   Reset clears the held count, the chord table and all handshake state;
//   the key cells hold no reset value since slots above the count are unused.
// ----------------------------------------------------------------------------
`default_nettype none

module key_chord_matcher
    import kcm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CHORD_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_MATCH  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   func_reg;
    logic [KEY_W-1:0]             ev_key_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         m_valid_reg, m_valid_next;
    out_item_t                    out_reg;
    chord_t                       chord_reg [REG_COUNT];

    logic [HELD_MAX-1:0][KEY_W-1:0] held_key;
    logic [HELD_MAX-1:0][KEY_W-1:0] next_key;
    logic [HELD_MAX:0]              kill;
    cell_ctl_t                      cell_ctl [HELD_MAX];
    logic                           present;
    logic                           out_free;
    match_t                         match;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign present   = kill[HELD_MAX];
    assign kill[0]   = 1'b0;

    // Commands for the cell row during the update step.
    always_comb begin
        for (int k = 0; k < HELD_MAX; k++) begin
            cell_ctl[k].shift  = (state_reg == ST_UPDATE) && (func_reg == FUNC_UP);
            cell_ctl[k].append = (state_reg == ST_UPDATE) && (func_reg == FUNC_DOWN) &&
                                 !present && (count_reg == CNT_W'(k));
        end
    end

    // Row of held key cells, each fed by its upper neighbor.
    for (genvar g = 0; g < HELD_MAX; g++) begin : g_cell
        if (g < HELD_MAX - 1) begin : g_mid
            assign next_key[g] = held_key[g+1];
        end else begin : g_top
            assign next_key[g] = held_key[g];
        end

        kcm_cell u_cell (
            .aclk     (aclk),
            .ctl      (cell_ctl[g]),
            .ev_key   (ev_key_reg),
            .occupied (count_reg > CNT_W'(g)),
            .kill_in  (kill[g]),
            .next_key (next_key[g]),
            .kill_out (kill[g+1]),
            .key      (held_key[g])
        );
    end

    kcm_match u_match (
        .held_key (held_key[CHORD_KEYS-1:0]),
        .count    (count_reg),
        .chords   (chord_reg[0:NUM_CHORDS-1]),
        .result   (match)
    );

    // Sequencer, held count and output register.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ovf_next   = 1'b0;
                state_next = ST_MATCH;
                if (func_reg == FUNC_DOWN && !present) begin
                    if (count_reg < CNT_W'(HELD_MAX)) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else if (func_reg == FUNC_UP && present) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_MATCH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (match.fired) begin
                        count_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Event capture and result payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg   <= s_data.func;
            ev_key_reg <= s_data.key_code;
        end
        if (state_reg == ST_MATCH && out_free) begin
            out_reg.fired       <= match.fired;
            out_reg.action_code <= match.code;
            out_reg.overflow    <= ovf_reg;
            out_reg.held_count  <= match.fired ? 4'd0 : 4'(count_reg);
        end
    end

    // Chord table writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < REG_COUNT; r++) begin
                chord_reg[r] <= '0;
            end
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            chord_reg[cfg_index[REG_IDX_W-1:0]] <= chord_t'(cfg_data);
        end
    end

endmodule

`default_nettype wire

FILE: sv/kcm_checker.sv
// ----------------------------------------------------------------------------
// Key chord matcher checker
// Port-level checks on the result stream and event input, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_chord_matcher_macros.svh"

module kcm_checker
    import kcm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data
);

    // A stalled result item holds its payload.
    `KCM_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // A firing chord always empties the held set.
    `KCM_ASSERT_IMP(a_fire_clears, m_valid && m_data.fired, m_data.held_count == 4'd0)

    // No action code without a firing chord.
    `KCM_ASSERT_IMP(a_code_zero, m_valid && !m_data.fired, m_data.action_code == 8'd0)

    // A dropped key means the set is full, too large for any chord.
    `KCM_ASSERT_IMP(a_ovf_full, m_valid && m_data.overflow,
                    !m_data.fired && (m_data.held_count == 4'(HELD_MAX)))

    // One event at a time: input closes right after an item is taken.
    `KCM_ASSERT_NXT(a_one_item, s_valid && s_ready, !s_ready)

endmodule

bind key_chord_matcher kcm_checker u_kcm_checker (.*);

`default_nettype wire
